@@ hw/rtl/indexed_min_heap_decrease_key_unit_assert.svh @@
// assertion macros for the heap unit checker
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define IMH_ASSERT_IMPL(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("heap check failed");

// property that holds on the edge after the antecedent
`define IMH_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("heap check failed");

`endif

@@ hw/rtl/imh_pkg.sv @@
// ----------------------------------------------------------------------------
// imh_pkg
// shared constants and types for the indexed min-heap unit
// ----------------------------------------------------------------------------
package imh_pkg;
  localparam int MaxNodes = 1024;
  localparam int KeyWidth = 32;
  localparam int IdxW     = $clog2(MaxNodes);
  localparam int SlotW    = IdxW + 1;

  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [SlotW-1:0]    slot_t;
  typedef logic [KeyWidth-1:0] key_t;

  localparam logic [1:0] REQ_RESET   = 2'd0;
  localparam logic [1:0] REQ_DECR    = 2'd1;
  localparam logic [1:0] REQ_EXTRACT = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    idx_t       node_id;
    key_t       key_value;
    slot_t      node_count;
  } req_t;

  typedef struct packed {
    idx_t out_node;
    key_t out_key;
    logic heap_empty;
    logic request_ignored;
  } res_t;

  // memory access bundle from the sequencer
  typedef struct packed {
    logic  hs_we;
    idx_t  hs_waddr;
    idx_t  hs_wdata;
    idx_t  hs_raddr;
    logic  nk_we;
    idx_t  nk_waddr;
    key_t  nk_wdata;
    idx_t  nk_raddr;
    logic  ns_we;
    idx_t  ns_waddr;
    slot_t ns_wdata;
    idx_t  ns_raddr;
  } mem_req_t;

  typedef struct packed {
    idx_t  hs_rdata;
    key_t  nk_rdata;
    slot_t ns_rdata;
  } mem_rsp_t;
endpackage

@@ hw/rtl/indexed_min_heap_decrease_key_unit.sv @@
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_unit
// indexed binary min-heap with decrease-key and extract-min
// ----------------------------------------------------------------------------
// channel | dir | content
// in_*    | in  | tdata: req_type, node_id, key_value, node_count
// out_*   | out | tdata: out_node, out_key, heap_empty, request_ignored
//
// one request at a time; reset fills the first node_count slots, decrease-key
// sifts the node up level by level, extract sifts the last node down level by level
// (each dependent access waits for the registered ram read data)
// rst_n clears heap size and node count; ram contents stay undefined
// a result is held on the output until taken; no new request until then
module indexed_min_heap_decrease_key_unit import imh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,  // req_type, node_id, key_value, node_count
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata  // out_node, out_key, heap_empty, request_ignored
);
  req_t     req;
  res_t     res;
  mem_req_t mreq;
  mem_rsp_t mrsp;

  assign req.req_type   = in_tdata[1:0];
  assign req.node_id    = in_tdata[11:2];
  assign req.key_value  = in_tdata[43:12];
  assign req.node_count = in_tdata[54:44];

  assign out_tdata = {4'b0, res.request_ignored, res.heap_empty, res.out_key,
                      res.out_node};

  imh_seq u_seq (
    .clk(clk), .rst_n(rst_n), .req_valid(in_tvalid), .req_ready(in_tready),
    .req(req), .res_valid(out_tvalid), .res_ready(out_tready), .res(res),
    .mreq(mreq), .mrsp(mrsp)
  );

  imh_store u_store (.clk(clk), .mreq(mreq), .mrsp(mrsp));
endmodule

@@ hw/rtl/imh_ram.sv @@
// ----------------------------------------------------------------------------
// imh_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module imh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/imh_store.sv @@
// ----------------------------------------------------------------------------
// imh_store
// heap slot array, node key array and node slot array
// ----------------------------------------------------------------------------
module imh_store import imh_pkg::*; (
  input  logic     clk,
  input  mem_req_t mreq,
  output mem_rsp_t mrsp
);
  imh_ram #(.Width(IdxW), .Depth(MaxNodes)) u_heap_slots (
    .clk(clk), .we(mreq.hs_we), .waddr(mreq.hs_waddr), .wdata(mreq.hs_wdata),
    .raddr(mreq.hs_raddr), .rdata(mrsp.hs_rdata)
  );
  imh_ram #(.Width(KeyWidth), .Depth(MaxNodes)) u_node_keys (
    .clk(clk), .we(mreq.nk_we), .waddr(mreq.nk_waddr), .wdata(mreq.nk_wdata),
    .raddr(mreq.nk_raddr), .rdata(mrsp.nk_rdata)
  );
  imh_ram #(.Width(SlotW), .Depth(MaxNodes)) u_node_slot (
    .clk(clk), .we(mreq.ns_we), .waddr(mreq.ns_waddr), .wdata(mreq.ns_wdata),
    .raddr(mreq.ns_raddr), .rdata(mrsp.ns_rdata)
  );
endmodule

@@ hw/rtl/imh_seq.sv @@
// ----------------------------------------------------------------------------
// imh_seq
// request sequencer: reset fill, sift-up, extract and sift-down
// ----------------------------------------------------------------------------
module imh_seq import imh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     req_valid,
  output logic     req_ready,
  input  req_t     req,
  output logic     res_valid,
  input  logic     res_ready,
  output res_t     res,
  output mem_req_t mreq,
  input  mem_rsp_t mrsp
);
  typedef enum logic [4:0] {
    ST_IDLE, ST_FILL,
    ST_DK_RD, ST_DK_CHK,
    ST_UP_RD, ST_UP_PK, ST_UP_CMP,
    ST_EX_RD, ST_EX_KEY, ST_EX_LAST, ST_EX_MOVE,
    ST_DN_CUR, ST_DN_CK, ST_DN_L, ST_DN_LK, ST_DN_R, ST_DN_RK, ST_DN_SWAP,
    ST_RESULT
  } state_t;

  state_t state_r;
  slot_t  size_r, active_r, cnt_r, fill_r;
  slot_t  cur_r, oth_r, best_r;
  idx_t   curn_r, othn_r, bestn_r, root_r;
  key_t   curk_r, bestk_r;
  res_t   res_r;
  logic   up_swap;

  assign up_swap = (state_r == ST_UP_CMP) && (cur_r != '0) && (curk_r < mrsp.nk_rdata);

  always_comb begin
    mreq = '0;
    mreq.hs_raddr = '0;
    case (state_r)
      ST_FILL: begin
        if (fill_r < cnt_r) begin
          mreq.hs_we = 1'b1; mreq.hs_waddr = fill_r[IdxW-1:0];
          mreq.hs_wdata = fill_r[IdxW-1:0];
          mreq.nk_we = 1'b1; mreq.nk_waddr = fill_r[IdxW-1:0]; mreq.nk_wdata = '1;
          mreq.ns_we = 1'b1; mreq.ns_waddr = fill_r[IdxW-1:0]; mreq.ns_wdata = fill_r;
        end
      end
      ST_DK_RD: mreq.ns_raddr = curn_r;
      // parent slot of cur
      ST_UP_RD: mreq.hs_raddr = idx_t'((cur_r - 1'b1) >> 1);
      ST_UP_PK: mreq.nk_raddr = mrsp.hs_rdata;
      ST_EX_RD: mreq.hs_raddr = '0;
      ST_EX_KEY: begin
        mreq.nk_raddr = mrsp.hs_rdata;
        mreq.hs_raddr = size_r[IdxW-1:0] - 1'b1;
      end
      ST_EX_LAST: mreq.nk_raddr = mrsp.hs_rdata;
      ST_DN_CUR: mreq.hs_raddr = oth_r[IdxW-1:0];
      ST_DN_CK:  mreq.nk_raddr = mrsp.hs_rdata;
      ST_DN_L:   mreq.hs_raddr = oth_r[IdxW-1:0];
      ST_DN_R:   mreq.nk_raddr = mrsp.hs_rdata;
      default: ;
    endcase
    // writes of a swap: the other node moves to the cur slot; the current node is written at its final place
    if (up_swap) begin
      mreq.hs_we = 1'b1; mreq.hs_waddr = cur_r[IdxW-1:0]; mreq.hs_wdata = othn_r;
      mreq.ns_we = 1'b1; mreq.ns_waddr = othn_r; mreq.ns_wdata = cur_r;
    end
    if (state_r == ST_DN_SWAP && best_r != cur_r) begin
      mreq.hs_we = 1'b1; mreq.hs_waddr = cur_r[IdxW-1:0]; mreq.hs_wdata = bestn_r;
      mreq.ns_we = 1'b1; mreq.ns_waddr = bestn_r; mreq.ns_wdata = cur_r;
    end
    // final placement of the moving node
    if ((state_r == ST_UP_CMP && !up_swap) ||
        (state_r == ST_DN_SWAP && best_r == cur_r)) begin
      mreq.hs_we = 1'b1; mreq.hs_waddr = cur_r[IdxW-1:0]; mreq.hs_wdata = curn_r;
      mreq.ns_we = 1'b1; mreq.ns_waddr = curn_r; mreq.ns_wdata = cur_r;
    end
    if (state_r == ST_DK_CHK && !(mrsp.ns_rdata >= size_r)) begin
      mreq.nk_we = 1'b1; mreq.nk_waddr = curn_r; mreq.nk_wdata = curk_r;
    end
    if (state_r == ST_EX_MOVE) begin
      mreq.ns_we = 1'b1; mreq.ns_waddr = root_r; mreq.ns_wdata = slot_t'(MaxNodes);
    end
  end

  assign req_ready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RESULT);
  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      size_r <= '0;
      active_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: if (req_valid) begin
          res_r <= '0;
          curn_r <= req.node_id;
          curk_r <= req.key_value;
          case (req.req_type)
            REQ_RESET: begin
              cnt_r <= (req.node_count > slot_t'(MaxNodes)) ? slot_t'(MaxNodes)
                                                            : req.node_count;
              fill_r <= '0;
              state_r <= ST_FILL;
            end
            REQ_DECR: begin
              if ({1'b0, req.node_id} >= active_r) begin
                res_r.request_ignored <= 1'b1;
                state_r <= ST_RESULT;
              end else begin
                state_r <= ST_DK_RD;
              end
            end
            REQ_EXTRACT: begin
              if (size_r == '0) begin
                res_r.heap_empty <= 1'b1;
                state_r <= ST_RESULT;
              end else begin
                state_r <= ST_EX_RD;
              end
            end
            default: state_r <= ST_RESULT;
          endcase
        end
        ST_FILL: begin
          if (fill_r >= cnt_r) begin
            size_r <= cnt_r;
            active_r <= cnt_r;
            state_r <= ST_RESULT;
          end else begin
            fill_r <= fill_r + 1'b1;
          end
        end
        ST_DK_RD: state_r <= ST_DK_CHK;
        ST_DK_CHK: begin
          if (mrsp.ns_rdata >= size_r) begin
            res_r.request_ignored <= 1'b1;
            state_r <= ST_RESULT;
          end else begin
            cur_r <= mrsp.ns_rdata;
            state_r <= ST_UP_RD;
          end
        end
        ST_UP_RD: begin
          // parent of cur, or place directly at the root
          oth_r <= (cur_r - 1'b1) >> 1;
          if (cur_r == '0) begin
            state_r <= ST_UP_CMP;
          end else begin
            state_r <= ST_UP_PK;
          end
        end
        ST_UP_PK: begin
          othn_r <= mrsp.hs_rdata;
          state_r <= ST_UP_CMP;
        end
        ST_UP_CMP: begin
          if (up_swap) begin
            cur_r <= oth_r;
            state_r <= ST_UP_RD;
          end else begin
            state_r <= ST_RESULT;
          end
        end
        ST_EX_RD: state_r <= ST_EX_KEY;
        ST_EX_KEY: begin
          root_r <= mrsp.hs_rdata;
          res_r.out_node <= mrsp.hs_rdata;
          size_r <= size_r - 1'b1;
          state_r <= ST_EX_LAST;
        end
        ST_EX_LAST: begin
          res_r.out_key <= mrsp.nk_rdata;
          curn_r <= mrsp.hs_rdata;
          cur_r <= '0;
          state_r <= ST_EX_MOVE;
        end
        ST_EX_MOVE: begin
          curk_r <= mrsp.nk_rdata;
          if (size_r == '0) begin
            state_r <= ST_RESULT;
          end else begin
            oth_r <= slot_t'(1);
            best_r <= '0;
            bestn_r <= curn_r;
            bestk_r <= mrsp.nk_rdata;
            state_r <= ST_DN_CUR;
          end
        end
        ST_DN_CUR: begin
          best_r <= cur_r;
          bestn_r <= curn_r;
          bestk_r <= curk_r;
          if (oth_r >= size_r) begin
            state_r <= ST_DN_SWAP;
          end else begin
            state_r <= ST_DN_CK;
          end
        end
        ST_DN_CK: state_r <= ST_DN_LK;
        ST_DN_LK: begin
          if (mrsp.nk_rdata < bestk_r) begin
            best_r <= oth_r;
            bestn_r <= othn_r;
            bestk_r <= mrsp.nk_rdata;
          end
          oth_r <= oth_r + 1'b1;
          if (oth_r + 1'b1 >= size_r) begin
            state_r <= ST_DN_SWAP;
          end else begin
            state_r <= ST_DN_L;
          end
        end
        ST_DN_L: state_r <= ST_DN_R;
        ST_DN_R: begin
          othn_r <= mrsp.hs_rdata;
          state_r <= ST_DN_RK;
        end
        ST_DN_RK: begin
          if (mrsp.nk_rdata < bestk_r) begin
            best_r <= oth_r;
            bestn_r <= othn_r;
            bestk_r <= mrsp.nk_rdata;
          end
          state_r <= ST_DN_SWAP;
        end
        ST_DN_SWAP: begin
          if (best_r == cur_r) begin
            state_r <= ST_RESULT;
          end else begin
            cur_r <= best_r;
            oth_r <= {best_r[SlotW-2:0], 1'b1};
            state_r <= ST_DN_CUR;
          end
        end
        ST_RESULT: if (res_ready) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
      // left child node id captured from the read issued in ST_DN_CUR
      if (state_r == ST_DN_CK) othn_r <= mrsp.hs_rdata;
    end
  end
endmodule

@@ hw/rtl/imh_checker.sv @@
// ----------------------------------------------------------------------------
// imh_checker
// port-level checks for the heap unit
// ----------------------------------------------------------------------------
`include "indexed_min_heap_decrease_key_unit_assert.svh"
module imh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  // one request in flight: no input while a result waits
  `IMH_ASSERT_IMPL(a_excl, out_tvalid, !in_tready)
  // flags never both set
  `IMH_ASSERT_IMPL(a_flags, out_tvalid, !(out_tdata[42] && out_tdata[43]))
  // flagged results carry no node
  `IMH_ASSERT_IMPL(a_flag_zero, out_tvalid && (out_tdata[42] || out_tdata[43]),
                   out_tdata[41:0] == 42'd0)
  // stalled result holds
  `IMH_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

bind indexed_min_heap_decrease_key_unit imh_checker u_imh_checker (.*);

@@ tb/indexed_min_heap_decrease_key_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_unit_test
// directed and randomized stream test of the indexed min-heap with a behavioral heap model
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key_unit_test;
  import imh_pkg::*;

  localparam int LIMIT = 3000000;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0] req;
    idx_t node;
    key_t key;
    slot_t cnt;
    logic chk;
    idx_t e_node;
    key_t e_key;
    logic e_empty;
    logic e_ign;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;  // req_type, node_id, key_value, node_count
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;  // out_node, out_key, heap_empty, request_ignored

  idx_t heap_arr [MaxNodes];
  key_t key_arr [MaxNodes];
  int slot_arr [MaxNodes];
  int heap_len;
  int node_total;

  res_t pending_results [$];
  int errors;
  int cycles;
  int send_idle;
  int recv_stall;
  bit hold_recv;
  int phase;

  always #1 clk = ~clk;

  indexed_min_heap_decrease_key_unit uut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("indexed_min_heap_decrease_key_unit: mismatch");
      $finish;
    end
  end

  function automatic key_t key_of(int s);
    return key_arr[heap_arr[s]];
  endfunction

  function automatic void swap_slots(int a, int b);
    idx_t na;
    idx_t nb;
    na = heap_arr[a];
    nb = heap_arr[b];
    heap_arr[a] = nb;
    heap_arr[b] = na;
    slot_arr[nb] = a;
    slot_arr[na] = b;
  endfunction

  function automatic res_t heap_apply(logic [1:0] req, idx_t node, key_t key, slot_t cnt);
    res_t r;
    int n;
    int s;
    int p;
    int best;
    idx_t root;
    r = '0;
    case (req)
      REQ_RESET: begin
        n = (cnt > MaxNodes) ? MaxNodes : cnt;
        for (int i = 0; i < n; i++) begin
          heap_arr[i] = idx_t'(i);
          key_arr[i] = '1;
          slot_arr[i] = i;
        end
        heap_len = n;
        node_total = n;
      end
      REQ_DECR: begin
        if (node >= node_total || slot_arr[node] >= heap_len) begin
          r.request_ignored = 1'b1;
        end else begin
          key_arr[node] = key;
          s = slot_arr[node];
          while (s > 0) begin
            p = (s - 1) / 2;
            if (key_of(s) < key_of(p)) begin
              swap_slots(s, p);
              s = p;
            end else break;
          end
        end
      end
      REQ_EXTRACT: begin
        if (heap_len == 0) begin
          r.heap_empty = 1'b1;
        end else begin
          root = heap_arr[0];
          r.out_node = root;
          r.out_key = key_arr[root];
          heap_len--;
          if (heap_len > 0) begin
            heap_arr[0] = heap_arr[heap_len];
            slot_arr[heap_arr[0]] = 0;
            s = 0;
            forever begin
              best = s;
              if (2*s+1 < heap_len && key_of(2*s+1) < key_of(best)) best = 2*s+1;
              if (2*s+2 < heap_len && key_of(2*s+2) < key_of(best)) best = 2*s+2;
              if (best == s) break;
              swap_slots(s, best);
              s = best;
            end
          end
          slot_arr[root] = MaxNodes;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_req(logic [1:0] req, idx_t node, key_t key, slot_t cnt,
                          logic chk = 1'b0, res_t typed = '0);
    res_t r;
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk);
    r = heap_apply(req, node, key, cnt);
    if (chk && r != typed) begin
      errors++;
      if (errors <= 10) $display("table row disagrees: typed %h model %h", typed, r);
    end
    pending_results.push_back(r);
    in_tdata <= {1'b0, cnt, key, node, req};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (!rst_n || hold_recv) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.out_node = out_tdata[9:0];
      got.out_key = out_tdata[41:10];
      got.heap_empty = out_tdata[42];
      got.request_ignored = out_tdata[43];
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("node %0d/%0d key %h/%h empty %b/%b ign %b/%b (exp/act)",
                     want.out_node, got.out_node, want.out_key, got.out_key,
                     want.heap_empty, got.heap_empty, want.request_ignored,
                     got.request_ignored);
        end
      end
    end
  end

  task automatic drain;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic random_req(int small_n);
    int d;
    d = $urandom_range(99);
    if (d < 3)
      send_req(REQ_RESET, '0, '0, slot_t'(($urandom_range(9) == 0) ?
               $urandom_range(2047) : $urandom_range(small_n)));
    else if (d < 55)
      send_req(REQ_DECR, idx_t'(($urandom_range(19) == 0) ? $urandom :
               $urandom_range(small_n)), key_t'($urandom), slot_t'($urandom));
    else if (d < 97)
      send_req(REQ_EXTRACT, idx_t'($urandom), key_t'($urandom), slot_t'($urandom));
    else
      send_req(REQ_UNKNOWN, idx_t'($urandom), key_t'($urandom), slot_t'($urandom));
  endtask

  initial begin
    row_t rows [$];
    res_t typed;
    errors = 0;
    cycles = 0;
    heap_len = 0;
    node_total = 0;
    send_idle = 0;
    recv_stall = 0;
    hold_recv = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed table; chk rows carry a hand-typed result
    rows = '{
      '{REQ_EXTRACT, '0, '0, '0, 1, '0, '0, 1, 0},
      '{REQ_DECR, 10'd0, 32'd5, '0, 1, '0, '0, 0, 1},
      '{REQ_UNKNOWN, 10'h3ff, '1, 11'h7ff, 1, '0, '0, 0, 0},
      '{REQ_RESET, '0, '0, 11'd2047, 1, '0, '0, 0, 0},
      '{REQ_DECR, 10'd1023, 32'd0, '0, 0, '0, '0, 0, 0},
      '{REQ_DECR, 10'd512, 32'd0, '0, 0, '0, '0, 0, 0},
      '{REQ_EXTRACT, '0, '0, '0, 0, '0, '0, 0, 0},
      '{REQ_EXTRACT, '0, '0, '0, 0, '0, '0, 0, 0},
      '{REQ_DECR, 10'd1023, 32'd1, '0, 1, '0, '0, 0, 1},
      '{REQ_RESET, '0, '0, 11'd1, 1, '0, '0, 0, 0},
      '{REQ_EXTRACT, '0, '0, '0, 1, 10'd0, '1, 0, 0},
      '{REQ_EXTRACT, '0, '0, '0, 1, '0, '0, 1, 0},
      '{REQ_RESET, '0, '0, 11'd5, 0, '0, '0, 0, 0},
      '{REQ_DECR, 10'd5, 32'd1, '0, 1, '0, '0, 0, 1},
      '{REQ_DECR, 10'd4, 32'd7, '0, 0, '0, '0, 0, 0},
      '{REQ_DECR, 10'd3, 32'd7, '0, 0, '0, '0, 0, 0},
      '{REQ_DECR, 10'd2, '1, '0, 0, '0, '0, 0, 0},
      '{REQ_DECR, 10'd1, 32'hffff_fffe, '0, 0, '0, '0, 0, 0},
      '{REQ_EXTRACT, '0, '0, '0, 0, '0, '0, 0, 0},
      '{REQ_DECR, 10'd0, 32'd100, '0, 0, '0, '0, 0, 0},
      '{REQ_EXTRACT, '0, '0, '0, 0, '0, '0, 0, 0},
      '{REQ_RESET, '0, '0, 11'd0, 1, '0, '0, 0, 0},
      '{REQ_EXTRACT, '0, '0, '0, 1, '0, '0, 1, 0}
    };
    foreach (rows[i]) begin
      typed = '{rows[i].e_node, rows[i].e_key, rows[i].e_empty, rows[i].e_ign};
      send_req(rows[i].req, rows[i].node, rows[i].key, rows[i].cnt, rows[i].chk, typed);
    end
    drain;

    for (phase = 0; phase < 4; phase++) begin
      send_idle = (phase == 1 || phase == 3) ? ((phase == 1) ? 51 : 33) : 0;
      recv_stall = (phase == 2 || phase == 3) ? ((phase == 2) ? 51 : 33) : 0;
      send_req(REQ_RESET, '0, '0, slot_t'(phase == 0 ? 1024 : $urandom_range(1, 40)));
      for (int i = 0; i < 420; i++) random_req(phase == 0 ? 1023 : 48);
      drain;
    end

    // long receiver hold-off while requests keep coming
    send_idle = 0;
    recv_stall = 0;
    fork
      begin
        hold_recv = 1;
        repeat (300) @(negedge clk);
        hold_recv = 0;
      end
      for (int i = 0; i < 20; i++) random_req(16);
    join
    drain;

    if (errors == 0) $display("indexed_min_heap_decrease_key_unit: match");
    else $display("indexed_min_heap_decrease_key_unit: mismatch");
    $finish;
  end
endmodule
